### sv/u8re_pkg.sv
// ============================================================================
// u8re_pkg: shared types, constants and helpers of the UTF-8 repair escaper
// Lead-byte decoding, hex digit lookup, escape phase codes and the
// command/status structs between controller and datapath.
// ============================================================================
`default_nettype none

package u8re_pkg;

	// Longest accepted UTF-8 group, in bytes
	localparam int unsigned MAX_SEQ = 6;
	// Width of group length, fill count and byte index
	localparam int unsigned GRP_W = $clog2(MAX_SEQ + 1);

	// ASCII characters of the escape text
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	// Position inside one escape "&#xHH;"
	typedef enum logic [2:0] {
		PH_AMP,
		PH_HASH,
		PH_X,
		PH_HI,
		PH_LO,
		PH_SEMI
	} esc_phase_t;

	// Controller state
	typedef enum logic [0:0] {
		ST_ACCEPT,
		ST_EMIT
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;   // input transfer this cycle
		logic step;     // load the next output character
	} u8re_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_emit;  // the byte on the input causes output
		logic slot_free;  // output register can take a character
		logic last_char;  // character at the sequencer is the final one
	} u8re_status_t;

	// Group length announced by a lead byte; 0 when it cannot start a group
	function automatic logic [GRP_W-1:0] lead_len(input logic [7:0] b);
		logic [GRP_W-1:0] n;
		n = '0;
		if (b[7] == 1'b0)              n = GRP_W'(1);
		else if (b[7:5] == 3'b110)     n = GRP_W'(2);
		else if (b[7:4] == 4'b1110)    n = GRP_W'(3);
		else if (b[7:3] == 5'b11110)   n = GRP_W'(4);
		else if (b[7:2] == 6'b111110)  n = GRP_W'(5);
		else if (b[7:1] == 7'b1111110) n = GRP_W'(6);
		if (n > GRP_W'(MAX_SEQ)) n = '0;
		return n;
	endfunction

	// Uppercase ASCII hex digit of a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) c = 8'h30 + {4'h0, v};
		else           c = 8'h37 + {4'h0, v};
		return c;
	endfunction

endpackage

`default_nettype wire

### sv/u8re_ctrl.sv
// ============================================================================
// u8re_ctrl: controller of the UTF-8 repair escaper
// Two-state machine: take one input byte, then sequence its output text.
// ============================================================================
`default_nettype none

module u8re_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  u8re_pkg::u8re_status_t     status,
	output u8re_pkg::u8re_cmd_t        cmd
);
	import u8re_pkg::*;

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.step   = 1'b0;
		case (state_q)
			ST_ACCEPT: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid && status.need_emit) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.step = status.slot_free;
				if (status.slot_free && status.last_char) state_d = ST_ACCEPT;
			end
			default: begin
				state_d = ST_ACCEPT;
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/u8re_dp.sv
// ============================================================================
// u8re_dp: datapath of the UTF-8 repair escaper
// Group byte store, group tracking, character sequencer and output register.
// ============================================================================
`default_nettype none

module u8re_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  in_last,
	input  u8re_pkg::u8re_cmd_t        cmd,
	output u8re_pkg::u8re_status_t     status,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_char,
	output logic                       run_last
);
	import u8re_pkg::*;

	// group state
	logic [7:0]       grp_q [MAX_SEQ];
	logic [GRP_W-1:0] grp_len_q;
	logic [GRP_W-1:0] grp_fill_q;
	logic             grp_broken_q;

	// sequencer state
	logic [GRP_W-1:0] em_count_q;
	logic [GRP_W-1:0] em_idx_q;
	logic             em_raw_q;
	esc_phase_t       em_phase_q;

	// output register
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_last_q;

	// decode of the incoming byte
	logic             grp_open;
	logic [GRP_W-1:0] in_len;
	logic [GRP_W-1:0] fill_inc;
	logic             grp_done;
	logic             broken_new;
	logic [GRP_W-1:0] wr_idx;
	logic [GRP_W-1:0] emit_count;
	logic             emit_raw;
	logic             need_emit;

	always_comb begin
		grp_open   = (grp_len_q != '0);
		in_len     = lead_len(in_byte);
		fill_inc   = grp_fill_q + GRP_W'(1);
		grp_done   = grp_open && (fill_inc >= grp_len_q);
		broken_new = grp_broken_q || (in_byte[7:6] != 2'b10);
		wr_idx     = grp_open ? grp_fill_q : '0;
		if (grp_open) begin
			need_emit  = grp_done || in_last;
			emit_count = grp_done ? grp_len_q : fill_inc;
			emit_raw   = grp_done && !broken_new;
		end else begin
			need_emit  = !((in_len >= GRP_W'(2)) && !in_last);
			emit_count = GRP_W'(1);
			emit_raw   = (in_len == GRP_W'(1));
		end
	end

	// group byte store, written one byte per transfer
	always_ff @(posedge clk) begin
		if (cmd.accept) grp_q[wr_idx[GRP_W-1:0]] <= in_byte;
	end

	// group tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_len_q    <= '0;
			grp_fill_q   <= '0;
			grp_broken_q <= 1'b0;
		end else if (cmd.accept) begin
			if (need_emit) begin
				grp_len_q    <= '0;
				grp_fill_q   <= '0;
				grp_broken_q <= 1'b0;
			end else if (grp_open) begin
				grp_fill_q   <= fill_inc;
				grp_broken_q <= broken_new;
			end else begin
				grp_len_q    <= in_len;
				grp_fill_q   <= GRP_W'(1);
				grp_broken_q <= 1'b0;
			end
		end
	end

	// character at the sequencer position
	logic [7:0] cur_byte;
	logic [7:0] cur_char;
	logic       byte_end;
	esc_phase_t phase_next;
	logic       last_char;
	logic       slot_free;

	always_comb begin
		cur_byte   = grp_q[em_idx_q];
		cur_char   = cur_byte;
		byte_end   = 1'b1;
		phase_next = PH_AMP;
		if (!em_raw_q) begin
			byte_end = 1'b0;
			case (em_phase_q)
				PH_AMP: begin
					cur_char   = CH_AMP;
					phase_next = PH_HASH;
				end
				PH_HASH: begin
					cur_char   = CH_HASH;
					phase_next = PH_X;
				end
				PH_X: begin
					cur_char   = CH_X;
					phase_next = (cur_byte[7:4] != 4'h0) ? PH_HI : PH_LO;
				end
				PH_HI: begin
					cur_char   = hex_char(cur_byte[7:4]);
					phase_next = PH_LO;
				end
				PH_LO: begin
					cur_char   = hex_char(cur_byte[3:0]);
					phase_next = PH_SEMI;
				end
				PH_SEMI: begin
					cur_char   = CH_SEMI;
					byte_end   = 1'b1;
					phase_next = PH_AMP;
				end
				default: begin
					cur_char   = CH_SEMI;
					byte_end   = 1'b1;
					phase_next = PH_AMP;
				end
			endcase
		end
		last_char = byte_end && (em_idx_q == em_count_q - GRP_W'(1));
		slot_free = !out_valid_q || out_ready;
	end

	// status to the controller
	assign status = '{need_emit: need_emit, slot_free: slot_free, last_char: last_char};

	// sequencer: loaded on a transfer, advanced once per emitted character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_count_q <= GRP_W'(1);
			em_idx_q   <= '0;
			em_raw_q   <= 1'b1;
			em_phase_q <= PH_AMP;
		end else if (cmd.accept) begin
			em_count_q <= emit_count;
			em_idx_q   <= '0;
			em_raw_q   <= emit_raw;
			em_phase_q <= PH_AMP;
		end else if (cmd.step && !last_char) begin
			em_phase_q <= phase_next;
			if (byte_end) em_idx_q <= em_idx_q + GRP_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_char_q <= cur_char;
			out_last_q <= last_char;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign run_last  = out_last_q;

	// an open group is never full and never longer than allowed
	a_fill_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(grp_len_q != '0) |-> (grp_fill_q < grp_len_q))
		else $error("group fill count reached group length while open");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(grp_len_q != GRP_W'(1)) && (grp_len_q <= GRP_W'(MAX_SEQ)))
		else $error("open group length out of range");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		em_idx_q < em_count_q)
		else $error("sequencer index beyond emitted byte count");

	a_step_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (slot_free && !cmd.accept))
		else $error("output step without free slot or during input transfer");

endmodule

`default_nettype wire

### sv/utf8_repair_escaper.sv
// ============================================================================
// utf8_repair_escaper: UTF-8 stream repair with numeric character escapes
// Valid UTF-8 groups pass through raw; broken groups, stray continuation
// bytes and invalid leads are rewritten as "&#xHH;" text, "&#xH;" below 10h.
// ============================================================================
// Flow: an input transfer loads the character sequencer; the controller then
//   moves each output character into the output register that drives m_tdata.
// The sequencer emits one character per cycle while the output slot is free (raw
//   byte 1 character, escaped byte 5 or 6); no new input byte is taken until the
//   last character of the previous one is loaded. A byte that only extends an open group emits nothing.
// Reset (arst_n low, asynchronous) closes any open group and empties the output.
`default_nettype none

module utf8_repair_escaper (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // in_last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_char
	output logic            m_tlast    // run_last
);
	import u8re_pkg::*;

	u8re_cmd_t    cmd;
	u8re_status_t status;

	u8re_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	u8re_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.run_last  (m_tlast)
	);

endmodule

`default_nettype wire
